@@ hdl/adw_pkg.sv @@
// Shared types, constants and rounding helpers for the AdamW element update.
// No dependencies; imported by every module of the block.
package adw_pkg;

    localparam int WORD_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_KEEP = 2'd2;

    localparam logic [WORD_W-1:0] CLIP_GAIN_RST  = 32'd2147483648;
    localparam logic [WORD_W-1:0] STEP_SIZE_RST  = 32'd1697;
    localparam logic [WORD_W-1:0] DECAY_KEEP_RST = 32'd2147483219;

    // Moment coefficients, Q1.31
    localparam logic signed [31:0] BETA1       = 32'sd1932735283;
    localparam logic signed [31:0] ONE_M_BETA1 = 32'sd214748365;
    localparam logic [31:0]        BETA2       = 32'd2145336164;
    localparam logic [21:0]        ONE_M_BETA2 = 22'd2147484;
    // 1e-8 in Q4.28
    localparam logic [30:0]        EPS_Q28     = 31'd3;

    // Square root: 30 result bits, 3 per stage
    localparam int SQ_BITS = 30;
    localparam int SQ_PER  = 3;
    localparam int SQ_LAT  = SQ_BITS / SQ_PER;
    // Divider: 64 quotient bits, 4 per stage
    localparam int DV_BITS = 64;
    localparam int DV_PER  = 4;
    localparam int DV_LAT  = DV_BITS / DV_PER;

    typedef struct packed {
        logic signed [31:0] gradient;
        logic signed [31:0] weight;
        logic signed [31:0] first_moment;
        logic [31:0]        second_moment;
        logic               last_in_array;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] new_weight;
        logic signed [31:0] new_first_moment;
        logic [31:0]        new_second_moment;
        logic               saturated;
        logic               last_out;
    } t_out_word;

    // Values that ride alongside the root and divide pipes
    typedef struct packed {
        logic signed [33:0] w1;
        logic signed [31:0] m_new;
        logic [31:0]        v_new;
        logic [63:0]        num;
        logic               flag;
        logic               last;
    } t_side;

    typedef struct packed {
        logic               flag;
        logic signed [31:0] val;
    } t_sat;

    // Shift right by 31, round to nearest, ties away from zero
    function automatic logic signed [33:0] rnd31(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] sum;
        logic [33:0] r;
        mag = x[63] ? (~x + 64'd1) : x;
        sum = mag + 64'd1073741824;
        r   = {1'b0, sum[63:31]};
        return x[63] ? signed'(~r + 34'd1) : signed'(r);
    endfunction

    function automatic t_sat sat_s32(input logic signed [65:0] x);
        t_sat s;
        if (x > 66'sd2147483647) begin
            s.flag = 1'b1;
            s.val  = 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            s.flag = 1'b1;
            s.val  = 32'sh80000000;
        end else begin
            s.flag = 1'b0;
            s.val  = x[31:0];
        end
        return s;
    endfunction

endpackage

@@ hdl/adw_sqrt.sv @@
// Pipelined digit-by-digit square root, SQ_PER result bits per stage.
// Depends on adw_pkg. Gives floor root and remainder; rounding is done outside.
module adw_sqrt (
    input  logic                     i_clk,
    input  logic                     i_ce,
    input  logic [59:0]              i_rad,
    output logic [adw_pkg::SQ_BITS-1:0] o_root,
    output logic [33:0]              o_rem
);
    import adw_pkg::*;

    logic [33:0]        r_rem  [SQ_LAT];
    logic [SQ_BITS-1:0] r_root [SQ_LAT];
    logic [59:0]        r_rad  [SQ_LAT];

    for (genvar s = 0; s < SQ_LAT; s++) begin : g_st
        logic [33:0]        rem_in, n_rem;
        logic [SQ_BITS-1:0] root_in, n_root;
        logic [59:0]        rad_in, n_rad;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign rad_in  = r_rad[s-1];
        end

        always_comb begin
            n_rem  = rem_in;
            n_root = root_in;
            n_rad  = rad_in;
            for (int k = 0; k < SQ_PER; k++) begin
                n_rem = {n_rem[31:0], n_rad[59:58]};
                n_rad = {n_rad[57:0], 2'b00};
                if (n_rem >= {2'b00, n_root, 2'b01}) begin
                    n_rem  = n_rem - {2'b00, n_root, 2'b01};
                    n_root = {n_root[SQ_BITS-2:0], 1'b1};
                end else begin
                    n_root = {n_root[SQ_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_rad[s]  <= n_rad;
            end
        end
    end

    assign o_root = r_root[SQ_LAT-1];
    assign o_rem  = r_rem[SQ_LAT-1];

endmodule

@@ hdl/adw_div.sv @@
// Pipelined restoring divider, 64-bit dividend by 31-bit divisor, DV_PER bits per stage.
// Depends on adw_pkg.
module adw_div (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [63:0] i_num,
    input  logic [30:0] i_den,
    output logic [63:0] o_quo
);
    import adw_pkg::*;

    logic [30:0] r_rem [DV_LAT];
    logic [63:0] r_num [DV_LAT];
    logic [63:0] r_quo [DV_LAT];
    logic [30:0] r_den [DV_LAT];

    for (genvar s = 0; s < DV_LAT; s++) begin : g_st
        logic [30:0] rem_in, n_rem, den_in;
        logic [63:0] num_in, n_num, quo_in, n_quo;
        logic [31:0] part;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign num_in = r_num[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_num = num_in;
            n_quo = quo_in;
            part  = '0;
            for (int k = 0; k < DV_PER; k++) begin
                part  = {n_rem, n_num[63]};
                n_num = {n_num[62:0], 1'b0};
                if (part >= {1'b0, den_in}) begin
                    part  = part - {1'b0, den_in};
                    n_quo = {n_quo[62:0], 1'b1};
                end else begin
                    n_quo = {n_quo[62:0], 1'b0};
                end
                n_rem = part[30:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s] <= n_rem;
                r_num[s] <= n_num;
                r_quo[s] <= n_quo;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[DV_LAT-1];

endmodule

@@ hdl/adamw_element_update.sv @@
// AdamW update of one parameter element per word. Takes one input word every
// cycle unless the pipe holds, and returns one result word per input, in order,
// through five multiply/round stages, a 10-stage square root (3 root bits per stage),
// one divisor-forming stage, a 16-stage divider (4 quotient bits per stage) and the
// output register. The whole pipe advances on one enable; it holds while a result
// waits at the output and the output side is not ready. All values are Q4.28 (second
// moment unsigned); the clip factor and decay_keep are unsigned Q1.31 and are to be
// written by the user through the config port only while the block is empty (not
// enforced by the block). Results round to nearest and saturate; saturated marks any
// clamp, including of the scaled gradient. Depends on adw_pkg, adw_sqrt and adw_div.
module adamw_element_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  adw_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output adw_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_we,
    input  logic [adw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [adw_pkg::WORD_W-1:0]          i_cfg_data
);
    import adw_pkg::*;

    // valid bits: stages 1..5, root pipe, divisor stage, divide pipe
    localparam int NSTG = 5 + SQ_LAT + 1 + DV_LAT;

    logic        ce, in_acc;
    logic [NSTG-1:0] r_vld;

    logic [31:0] r_clip, r_step, r_decay;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip  <= CLIP_GAIN_RST;
            r_step  <= STEP_SIZE_RST;
            r_decay <= DECAY_KEEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLIP_GAIN:  r_clip  <= i_cfg_data;
                CFG_STEP_SIZE:  r_step  <= i_cfg_data;
                CFG_DECAY_KEEP: r_decay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the output register is free or being drained
    assign ce         = !o_out_valid || i_out_ready;
    assign o_in_ready = ce;
    assign in_acc     = i_in_valid && ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            o_out_valid <= 1'b0;
        end else if (ce) begin
            r_vld       <= {r_vld[NSTG-2:0], in_acc};
            o_out_valid <= r_vld[NSTG-1];
        end
    end

    // stage 1: clip and decay products
    logic signed [63:0] r1_pg, r1_pw;
    logic signed [31:0] r1_m;
    logic [31:0]        r1_v;
    logic               r1_last;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_pg   <= i_in_word.gradient * $signed({1'b0, r_clip});
            r1_pw   <= i_in_word.weight * $signed({1'b0, r_decay});
            r1_m    <= i_in_word.first_moment;
            r1_v    <= i_in_word.second_moment;
            r1_last <= i_in_word.last_in_array;
        end
    end

    // stage 2: round, clamp scaled gradient
    logic signed [31:0] r2_gc, r2_m;
    logic signed [33:0] r2_w1;
    logic [31:0]        r2_v;
    logic               r2_flag, r2_last;
    t_sat               gc_sat;

    assign gc_sat = sat_s32(66'(rnd31(r1_pg)));

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r2_gc   <= gc_sat.val;
            r2_flag <= gc_sat.flag;
            r2_w1   <= rnd31(r1_pw);
            r2_m    <= r1_m;
            r2_v    <= r1_v;
            r2_last <= r1_last;
        end
    end

    // stage 3: moment products and squared gradient
    logic signed [63:0] r3_p1, r3_p2;
    logic [63:0]        r3_g2, r3_a;
    logic signed [33:0] r3_w1;
    logic               r3_flag, r3_last;
    logic [31:0]        gmag;

    assign gmag = r2_gc[31] ? (~r2_gc + 32'd1) : r2_gc;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r3_p1   <= BETA1 * r2_m;
            r3_p2   <= ONE_M_BETA1 * r2_gc;
            r3_g2   <= gmag * gmag;
            r3_a    <= BETA2 * r2_v;
            r3_w1   <= r2_w1;
            r3_flag <= r2_flag;
            r3_last <= r2_last;
        end
    end

    // stage 4: new first moment; split g^2 * (1 - beta2)
    logic signed [31:0] r4_m;
    logic [57:0]        r4_bh;
    logic [21:0]        r4_bl;
    logic [63:0]        r4_a;
    logic signed [33:0] r4_w1;
    logic               r4_flag, r4_last;
    t_sat               m_sat;
    logic [49:0]        lo_prod;

    assign m_sat   = sat_s32(66'(rnd31(r3_p1 + r3_p2)));
    assign lo_prod = r3_g2[27:0] * ONE_M_BETA2 + 50'd134217728;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r4_m    <= m_sat.val;
            r4_bh   <= r3_g2[63:28] * ONE_M_BETA2;
            r4_bl   <= lo_prod[49:28];
            r4_a    <= r3_a;
            r4_w1   <= r3_w1;
            r4_flag <= r3_flag | m_sat.flag;
            r4_last <= r3_last;
        end
    end

    // stage 5: new second moment; step numerator
    t_side       r5_side;
    logic [64:0] vsum;
    logic [33:0] vrnd;
    logic [31:0] mmag;

    assign vsum = {1'b0, r4_a} + 65'(r4_bh) + 65'(r4_bl) + 65'd1073741824;
    assign vrnd = vsum[64:31];
    assign mmag = r4_m[31] ? (~r4_m + 32'd1) : r4_m;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r5_side.w1    <= r4_w1;
            r5_side.m_new <= r4_m;
            r5_side.v_new <= (vrnd[33:32] != 2'b00) ? 32'hFFFFFFFF : vrnd[31:0];
            r5_side.flag  <= r4_flag | (vrnd[33:32] != 2'b00);
            r5_side.num   <= r_step * mmag;
            r5_side.last  <= r4_last;
        end
    end

    // square root of v' in Q4.28
    logic [SQ_BITS-1:0] sq_root;
    logic [33:0]        sq_rem;
    t_side              r_sq_side [SQ_LAT];

    adw_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_rad  ({r5_side.v_new, 28'd0}),
        .o_root (sq_root),
        .o_rem  (sq_rem)
    );

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sq_side[0] <= r5_side;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    // divisor stage: round root, add eps, bias numerator by half divisor
    t_side       r6_side;
    logic [30:0] r6_den;
    logic [63:0] r6_num;
    logic [30:0] den;

    assign den = {1'b0, sq_root} + 31'(sq_rem > {4'd0, sq_root}) + EPS_Q28;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r6_side <= r_sq_side[SQ_LAT-1];
            r6_den  <= den;
            r6_num  <= r_sq_side[SQ_LAT-1].num + {34'd0, den[30:1]};
        end
    end

    // step quotient
    logic [63:0] quo;
    t_side       r_dv_side [DV_LAT];

    adw_div u_div (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r6_num),
        .i_den (r6_den),
        .o_quo (quo)
    );

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dv_side[0] <= r6_side;
            for (int k = 1; k < DV_LAT; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    // output stage: apply step with the sign of m', clamp weight
    t_side              fin;
    logic signed [65:0] wdiff;
    t_sat               w_sat;

    assign fin   = r_dv_side[DV_LAT-1];
    assign wdiff = fin.m_new[31] ? (66'(fin.w1) + $signed({2'b00, quo}))
                                 : (66'(fin.w1) - $signed({2'b00, quo}));
    assign w_sat = sat_s32(wdiff);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            o_out_word.new_weight        <= w_sat.val;
            o_out_word.new_first_moment  <= fin.m_new;
            o_out_word.new_second_moment <= fin.v_new;
            o_out_word.saturated         <= fin.flag | w_sat.flag;
            o_out_word.last_out          <= fin.last;
        end
    end

`ifndef SYNTHESIS
    // an accepted word occupies the first stage next cycle
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_vld[0])
        else $error("accepted word missing from stage 1");

    // a held pipe keeps every valid bit in place
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ce |=> $stable(r_vld))
        else $error("pipe moved while stalled");

    // a result appears only from a filled last stage
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_vld[NSTG-1]))
        else $error("result without a word in the last stage");
`endif

endmodule

@@ verif/tb_adamw_element_update.sv @@
// Testbench for adamw_element_update: directed table plus random words over several
// register settings, each checked against an in-bench AdamW predictor or a typed row.
// Depends on adw_pkg and the adamw_element_update RTL.
module tb_adamw_element_update;
    import adw_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register here
    localparam int WORDS_PER_PHASE = 250;
    localparam int N_PHASES        = 6;
    localparam int DRAIN_CYCLES    = 40;   // pipe is 33 deep
    localparam int LONG_HOLD       = 300;  // fills the pipe and stalls input

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_in_word           in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_word          out_word;
    logic               cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]  cfg_data = '0;

    // Predictor's copy of the registers
    logic [31:0] clip_q31, step_q28, keep_q31;

    t_out_word   pending_results[$];
    int          mismatches = 0;
    int          words_in = 0, words_out = 0, sat_seen = 0, last_seen = 0;
    bit          quiet_sender = 0, quiet_receiver = 0, long_hold_req = 0;

    always #4 i_clk = ~i_clk;

    adamw_element_update uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ---------------- predictor ----------------
    // Shift right by 31, round to nearest, ties away from zero
    function automatic longint round_q31(longint x);
        longint unsigned mag;
        if (x < 0) begin
            mag = longint'(-x);
            return -longint'((mag + 64'h4000_0000) >> 31);
        end
        return longint'((unsigned'(x) + 64'h4000_0000) >> 31);
    endfunction

    function automatic longint clamp_s32(longint x, inout bit clamped);
        if (x > 64'sd2147483647) begin
            clamped = 1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            clamped = 1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // Integer square root, rounded to nearest
    function automatic longint unsigned root_nearest(longint unsigned x);
        longint unsigned res, bt, rem;
        res = 0;
        bt  = 64'd1 << 62;
        rem = x;
        while (bt > x) bt >>= 2;
        while (bt != 0) begin
            if (rem >= res + bt) begin
                rem -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        if (rem > res) res++;
        return res;
    endfunction

    function automatic t_out_word adamw_step(t_in_word w);
        t_out_word       r;
        bit              clamped;
        longint          g, wt, m, gc, m_new, w1, upd, w_new;
        longint unsigned v, gmag, g2, b, vsum, v_new, dvs, mmag, q;
        clamped = 0;
        g  = longint'(w.gradient);
        wt = longint'(w.weight);
        m  = longint'(w.first_moment);
        v  = longint'(w.second_moment);

        gc    = clamp_s32(round_q31(g * longint'(clip_q31)), clamped);
        m_new = clamp_s32(round_q31(64'sd1932735283 * m + 64'sd214748365 * gc), clamped);

        // g^2 term: split at the Q28 point so only one rounding applies
        gmag = (gc < 0) ? longint'(-gc) : gc;
        g2   = gmag * gmag;
        b    = (g2 >> 28) * 64'd2147484
             + (((g2 & 64'hFFF_FFFF) * 64'd2147484 + 64'h800_0000) >> 28);
        vsum = 64'd2145336164 * v + b;
        v_new = (vsum + 64'h4000_0000) >> 31;
        if (v_new > 64'hFFFF_FFFF) begin
            v_new   = 64'hFFFF_FFFF;
            clamped = 1;
        end

        w1   = round_q31(wt * longint'(keep_q31));
        dvs  = root_nearest(v_new << 28) + 64'd3;   // eps keeps it nonzero
        mmag = (m_new < 0) ? longint'(-m_new) : m_new;
        q    = (longint'(step_q28) * mmag + (dvs >> 1)) / dvs;
        upd  = (m_new < 0) ? -longint'(q) : longint'(q);
        w_new = clamp_s32(w1 - upd, clamped);

        r.new_weight        = w_new[31:0];
        r.new_first_moment  = m_new[31:0];
        r.new_second_moment = v_new[31:0];
        r.saturated         = clamped;
        r.last_out          = w.last_in_array;
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_valid && out_ready) begin
            words_out++;
            if (out_word.saturated) sat_seen++;
            if (out_word.last_out) last_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", 32'h0, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (out_word.new_weight !== want.new_weight)
                    report_mismatch("new_weight", out_word.new_weight, want.new_weight);
                if (out_word.new_first_moment !== want.new_first_moment)
                    report_mismatch("new_first_moment", out_word.new_first_moment,
                                    want.new_first_moment);
                if (out_word.new_second_moment !== want.new_second_moment)
                    report_mismatch("new_second_moment", out_word.new_second_moment,
                                    want.new_second_moment);
                if (out_word.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(out_word.saturated),
                                    32'(want.saturated));
                if (out_word.last_out !== want.last_out)
                    report_mismatch("last_out", 32'(out_word.last_out),
                                    32'(want.last_out));
            end
        end
    end

    // ---------------- receiver ----------------
    // Draws a stall per result; a long hold is taken when the main flow asks.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = quiet_receiver ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(out_valid && out_ready));
        end
    end

    // ---------------- sender ----------------
    // valid stays up between back-to-back words; lowered ahead of a gap or by drain
    task automatic send_word(t_in_word w, bit typed, t_out_word typed_want);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!in_ready);
        pending_results.push_back(typed ? typed_want : adamw_step(w));
        words_in++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // after each write the enable is lowered before the task returns, keeping the enable pulses apart
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_CLIP_GAIN:  clip_q31 = val;
            CFG_STEP_SIZE:  step_q28 = val;
            CFG_DECAY_KEEP: keep_q31 = val;
            default: ;  // unmapped index, block ignores it
        endcase
        @(posedge i_clk);
    endtask

    // Mostly plausible training values, the rest raw noise over all bits
    function automatic t_in_word random_word();
        t_in_word w;
        w = {$urandom, $urandom, $urandom, $urandom, 1'b0};
        w.last_in_array = ($urandom_range(0, 15) == 0);
        if ($urandom_range(0, 3) != 0) begin
            w.gradient      = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            w.weight        = $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
            w.first_moment  = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            w.second_moment = $urandom_range(0, 32'h0010_0000);
        end
        return w;
    endfunction

    // ---------------- directed table ----------------
    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word want;
    } t_row;

    t_row rows[$];

    task automatic add_row(logic [31:0] g, logic [31:0] wt, logic [31:0] m,
                           logic [31:0] v, bit last);
        t_row r;
        r.w     = {g, wt, m, v, last};
        r.typed = 0;
        r.want  = '0;
        rows.push_back(r);
    endtask

    initial begin : main_flow
        logic [31:0] settings[4][3];
        t_row        zr;
        clip_q31 = CLIP_GAIN_RST;
        step_q28 = STEP_SIZE_RST;
        keep_q31 = DECAY_KEEP_RST;

        // all-zero element: every result is zero whatever the registers
        zr.w = '0; zr.typed = 1; zr.want = '0;
        rows.push_back(zr);
        zr.w.last_in_array = 1'b1; zr.want.last_out = 1'b1;
        rows.push_back(zr);
        add_row(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);     // gradient extremes
        add_row(32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0);
        add_row(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);     // weight extremes
        add_row(32'h0, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
        add_row(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b0);     // zero v, m at max
        add_row(32'h0, 32'h0, 32'h8000_0000, 32'h0, 1'b0);
        add_row(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);     // v at max
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);  // weight overflow
        add_row(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b0);
        add_row(32'h1000_0000, 32'h1000_0000, 32'h0100_0000, 32'h0100_0000, 1'b1);

        // register sets: extremes, above-1.0 factors, unit factors, then random
        settings[0] = '{32'h0, 32'hFFFF_FFFF, 32'h0};
        settings[1] = '{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF};
        settings[2] = '{32'h8000_0000, 32'h0, 32'h8000_0000};
        settings[3] = '{$urandom_range(0, 32'h8000_0000), $urandom,
                        $urandom_range(32'h7F00_0000, 32'h8000_0000)};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset values, then under the extreme registers
        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph >= 1 && ph <= 4) begin
                write_reg(CFG_CLIP_GAIN,  settings[ph-1][0]);
                write_reg(CFG_STEP_SIZE,  settings[ph-1][1]);
                write_reg(CFG_DECAY_KEEP, settings[ph-1][2]);
                if (ph == 1) write_reg(CFG_UNUSED, $urandom);
                if (ph == 1) foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
            end
            quiet_sender   = (ph == 3);
            quiet_receiver = (ph == 3);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if (ph == 2 && k == 20) long_hold_req = 1;  // input must back up
                send_word(random_word(), 1'b0, '0);
            end
            drain();
        end

        $display("Sent %0d words, %0d results checked across %0d register phases",
                 words_in, words_out, N_PHASES);
        $display("Results with clamping: %0d, end-of-array marks: %0d", sat_seen, last_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
